// ===== rtl/core/busy_fraction_worker_governor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Busy fraction worker governor assertion macros
// Concurrent checks clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BUSY_FRACTION_WORKER_GOVERNOR_UNIT_ASSERT_SVH
`define BUSY_FRACTION_WORKER_GOVERNOR_UNIT_ASSERT_SVH

// condition that holds at every edge
`define BFWG_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define BFWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bfwg_pkg.sv =====
// ----------------------------------------------------------------------------
// Busy fraction worker governor package
// Shared widths, codes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package bfwg_pkg;

	localparam int STAMP_W = 48;
	localparam int FRAC_W  = 16;
	localparam int WORK_W  = 8;
	localparam int WIN_W   = 6;
	localparam int LIM_W   = 7;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 16;

	localparam int RING_DEPTH_DEF   = 8;
	localparam int SPAN_FRAMES_DEF  = 6;
	localparam int HISTORY_BITS_DEF = 32;

	localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

	localparam logic [1:0] CHG_NONE   = 2'd0;
	localparam logic [1:0] CHG_GROW   = 2'd1;
	localparam logic [1:0] CHG_SHRINK = 2'd2;

	localparam logic [IDX_W-1:0] REG_SLOW_THR = 3'd0;
	localparam logic [IDX_W-1:0] REG_FAST_THR = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_WORK = 3'd2;
	localparam logic [IDX_W-1:0] REG_WINDOW   = 3'd3;
	localparam logic [IDX_W-1:0] REG_TOLER    = 3'd4;
	localparam logic [IDX_W-1:0] REG_SETTLE   = 3'd5;

	localparam logic [FRAC_W-1:0] SLOW_THR_RST = 16'd3277;
	localparam logic [FRAC_W-1:0] FAST_THR_RST = 16'd2048;
	localparam logic [WORK_W-1:0] MAX_WORK_RST = 8'd4;
	localparam logic [WIN_W-1:0]  WINDOW_RST   = 6'd15;
	localparam logic [WIN_W-1:0]  TOLER_RST    = 6'd3;
	localparam logic [WORK_W-1:0] SETTLE_RST   = 8'd15;
	localparam logic [WORK_W-1:0] WORKERS_RST  = 8'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_DECIDE
	} state_t;

endpackage

// ===== rtl/core/busy_fraction_worker_governor_unit.sv =====
// Per frame the sequencer steps through read, calc and decide; calc lasts until the
// one-bit-per-cycle divider and both history counters have finished.
// Frames are not overlapped: a new frame can be taken the cycle after the previous one
// reached the result register, while that result may still wait there.
// Reset: ring reads as zero, histories clear, settle count 15, one worker,
// configuration registers take their default values.
// ----------------------------------------------------------------------------
// Busy fraction worker governor
// Tracks frame busy fraction over a ring of end stamps and steers worker count.
// ----------------------------------------------------------------------------
module busy_fraction_worker_governor_unit #(
	parameter int RING_DEPTH   = bfwg_pkg::RING_DEPTH_DEF,
	parameter int SPAN_FRAMES  = bfwg_pkg::SPAN_FRAMES_DEF,
	parameter int HISTORY_BITS = bfwg_pkg::HISTORY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [bfwg_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bfwg_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         frame_valid,
	output logic                         frame_stall,
	input  logic [bfwg_pkg::STAMP_W-1:0] frame_start,
	input  logic [bfwg_pkg::STAMP_W-1:0] frame_end,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [bfwg_pkg::FRAC_W-1:0]  busy_frac,
	output logic [bfwg_pkg::WORK_W-1:0]  worker_count,
	output logic [1:0]                   count_change
);
	import bfwg_pkg::*;

	localparam int PW       = $clog2(RING_DEPTH);
	localparam int BACK_OFF = SPAN_FRAMES % RING_DEPTH;
	localparam bit SELF_RD  = BACK_OFF == 0;
	localparam int A_W      = STAMP_W + $clog2(SPAN_FRAMES + 1);
	localparam int HC_W     = $clog2(HISTORY_BITS + 1);

	// configuration
	logic [FRAC_W-1:0] slow_thr_q;
	logic [FRAC_W-1:0] fast_thr_q;
	logic [WORK_W-1:0] max_work_q;
	logic [WIN_W-1:0]  window_q;
	logic [WIN_W-1:0]  toler_q;
	logic [WORK_W-1:0] settle_cfg_q;

	// governor state
	state_t              state_q, state_d;
	logic [PW-1:0]       pos_q;
	logic [RING_DEPTH-1:0] ring_vld_q;
	logic [STAMP_W-1:0]  ring_mem [RING_DEPTH];
	logic [HISTORY_BITS-1:0] slow_hist_q;
	logic [HISTORY_BITS-1:0] fast_hist_q;
	logic [WORK_W-1:0]   settle_q;
	logic [WORK_W-1:0]   workers_q;

	// per-frame registers
	logic [STAMP_W-1:0] t0_q;
	logic [STAMP_W-1:0] t1_q;
	logic [STAMP_W-1:0] rd_s1;
	logic               rd_vld_s1;
	logic               sat_q;
	logic               zero_q;

	// result register
	logic              res_vld_q;
	logic [FRAC_W-1:0] res_frac_q;
	logic [WORK_W-1:0] res_work_q;
	logic [1:0]        res_chg_q;

	logic              accept;
	logic [PW:0]       back_wide;
	logic [PW-1:0]     back_idx;
	logic [PW-1:0]     pos_next;
	logic [STAMP_W-1:0] old_end;
	logic [STAMP_W-1:0] span;
	logic [STAMP_W-1:0] busy_time;
	logic [A_W-1:0]     scaled;
	logic               start_calc;
	logic               div_busy;
	logic               slow_busy;
	logic               fast_busy;
	logic [FRAC_W-1:0]  div_quo;
	logic [HC_W-1:0]    slow_cnt;
	logic [HC_W-1:0]    fast_cnt;
	logic [LIM_W-1:0]   w_eff;
	logic [LIM_W-1:0]   lim;
	logic [FRAC_W-1:0]  frac;
	logic               out_free;
	logic               commit;
	logic               slow_bit;
	logic               fast_bit;
	logic [WORK_W-1:0]  n_slow;
	logic [WORK_W-1:0]  n_fast;
	logic               grow;
	logic               shrink;

	assign accept      = frame_valid && !frame_stall;
	assign frame_stall = state_q != ST_IDLE;

	assign back_wide = ({1'b0, pos_q} >= (PW+1)'(BACK_OFF))
		? ({1'b0, pos_q} - (PW+1)'(BACK_OFF))
		: ({1'b0, pos_q} + (PW+1)'(RING_DEPTH - BACK_OFF));
	assign back_idx  = back_wide[PW-1:0];
	assign pos_next  = (pos_q == PW'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_thr_q   <= SLOW_THR_RST;
			fast_thr_q   <= FAST_THR_RST;
			max_work_q   <= MAX_WORK_RST;
			window_q     <= WINDOW_RST;
			toler_q      <= TOLER_RST;
			settle_cfg_q <= SETTLE_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SLOW_THR: slow_thr_q   <= cfg_data;
				REG_FAST_THR: fast_thr_q   <= cfg_data;
				REG_MAX_WORK: max_work_q   <= cfg_data[WORK_W-1:0];
				REG_WINDOW:   window_q     <= cfg_data[WIN_W-1:0];
				REG_TOLER:    toler_q      <= cfg_data[WIN_W-1:0];
				REG_SETTLE:   settle_cfg_q <= cfg_data[WORK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[pos_q] <= frame_end;
			rd_s1           <= ring_mem[back_idx];
			t0_q            <= frame_start;
			t1_q            <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ring_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else if (accept) begin
			pos_q             <= pos_next;
			ring_vld_q[pos_q] <= 1'b1;
			rd_vld_s1         <= ring_vld_q[back_idx];
		end
	end

	assign old_end   = SELF_RD ? t1_q : (rd_vld_s1 ? rd_s1 : '0);
	assign span      = t1_q - old_end;
	assign busy_time = t1_q - t0_q;
	assign scaled    = A_W'(busy_time) * A_W'(SPAN_FRAMES);
	assign start_calc = state_q == ST_READ;

	always_ff @(posedge clk) begin
		if (start_calc) begin
			sat_q  <= t1_q <= old_end;
			zero_q <= t1_q < t0_q;
		end
	end

	assign w_eff = ({1'b0, window_q} > LIM_W'(HISTORY_BITS))
		? LIM_W'(HISTORY_BITS) : {1'b0, window_q};
	assign lim   = (w_eff == '0) ? '0 : w_eff - 1'b1;

	bfwg_div #(
		.A_W(A_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_calc),
		.dividend (scaled),
		.divisor  (span),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	bfwg_hist #(
		.HB(HISTORY_BITS)
	) u_slow_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_calc),
		.hist   (slow_hist_q),
		.limit  (lim),
		.busy   (slow_busy),
		.count  (slow_cnt)
	);

	bfwg_hist #(
		.HB(HISTORY_BITS)
	) u_fast_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_calc),
		.hist   (fast_hist_q),
		.limit  (lim),
		.busy   (fast_busy),
		.count  (fast_cnt)
	);

	assign frac     = sat_q ? FRAC_MAX : (zero_q ? '0 : div_quo);
	assign slow_bit = frac > slow_thr_q;
	assign fast_bit = frac < fast_thr_q;
	assign n_slow   = WORK_W'(slow_cnt) + WORK_W'(slow_bit && (w_eff != '0));
	assign n_fast   = WORK_W'(fast_cnt) + WORK_W'(fast_bit && (w_eff != '0));
	assign grow     = (n_slow > WORK_W'(toler_q)) && (workers_q < max_work_q);
	assign shrink   = !grow && (n_slow == '0)
		&& ((n_fast + WORK_W'(toler_q)) >= WORK_W'(w_eff)) && (workers_q > WORKERS_RST);
	assign out_free = !res_vld_q || !result_stall;
	assign commit   = (state_q == ST_DECIDE) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_READ;
			ST_READ:   state_d = ST_CALC;
			ST_CALC:   if (!div_busy && !slow_busy && !fast_busy) state_d = ST_DECIDE;
			ST_DECIDE: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_hist_q <= '0;
			fast_hist_q <= '0;
			settle_q    <= SETTLE_RST;
			workers_q   <= WORKERS_RST;
		end else if (commit) begin
			if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end else if (grow || shrink) begin
				slow_hist_q <= '0;
				fast_hist_q <= '0;
				settle_q    <= settle_cfg_q;
				workers_q   <= grow ? workers_q + 1'b1 : workers_q - 1'b1;
			end else begin
				slow_hist_q <= {slow_hist_q[HISTORY_BITS-2:0], slow_bit};
				fast_hist_q <= {fast_hist_q[HISTORY_BITS-2:0], fast_bit};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (commit) begin
			res_vld_q <= 1'b1;
		end else if (!result_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_frac_q <= frac;
			if (settle_q == '0 && grow) begin
				res_work_q <= workers_q + 1'b1;
				res_chg_q  <= CHG_GROW;
			end else if (settle_q == '0 && shrink) begin
				res_work_q <= workers_q - 1'b1;
				res_chg_q  <= CHG_SHRINK;
			end else begin
				res_work_q <= workers_q;
				res_chg_q  <= CHG_NONE;
			end
		end
	end

	assign result_valid = res_vld_q;
	assign busy_frac    = res_frac_q;
	assign worker_count = res_work_q;
	assign count_change = res_chg_q;

	`include "busy_fraction_worker_governor_unit_assert.svh"

	`BFWG_ASSERT_ALWAYS(a_workers_nonzero, workers_q != '0, "worker count reached zero")
	`BFWG_ASSERT_ALWAYS(a_idle_div_quiet, (state_q != ST_IDLE) || !div_busy,
		"divider running while idle")
	`BFWG_ASSERT_NEXT(a_one_frame, accept, frame_stall, "second frame taken while working")

endmodule

// ===== rtl/core/bfwg_div.sv =====
// ----------------------------------------------------------------------------
// Busy fraction serial divider
// Restoring radix-2 divider, one quotient bit per cycle, Q4.12 saturating.
// ----------------------------------------------------------------------------
module bfwg_div #(
	parameter int A_W = 51
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [A_W-1:0]              dividend,
	input  logic [bfwg_pkg::STAMP_W-1:0] divisor,
	output logic                        busy,
	output logic [bfwg_pkg::FRAC_W-1:0] quotient
);
	import bfwg_pkg::*;

	localparam int STEPS = A_W + 12;
	localparam int C_W   = $clog2(STEPS + 1);

	logic [C_W-1:0]     cnt_q;
	logic [A_W-1:0]     num_q;
	logic [STAMP_W-1:0] den_q;
	logic [STAMP_W-1:0] rem_q;
	logic [FRAC_W-1:0]  quo_q;
	logic               ovf_q;

	logic [STAMP_W:0] rem_shift;
	logic [STAMP_W:0] rem_diff;
	logic             ge;

	assign rem_shift = {rem_q, num_q[A_W-1]};
	assign rem_diff  = rem_shift - {1'b0, den_q};
	assign ge        = rem_shift >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= C_W'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[A_W-2:0], 1'b0};
			rem_q <= ge ? rem_diff[STAMP_W-1:0] : rem_shift[STAMP_W-1:0];
			quo_q <= {quo_q[FRAC_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[FRAC_W-1];
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = ovf_q ? FRAC_MAX : quo_q;

endmodule

// ===== rtl/core/bfwg_hist.sv =====
// ----------------------------------------------------------------------------
// Busy fraction history counter
// Shifts a history word out one bit per cycle and counts ones below a limit.
// ----------------------------------------------------------------------------
module bfwg_hist #(
	parameter int HB = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [HB-1:0]              hist,
	input  logic [bfwg_pkg::LIM_W-1:0] limit,
	output logic                       busy,
	output logic [$clog2(HB+1)-1:0]    count
);
	import bfwg_pkg::*;

	localparam int N_W = $clog2(HB + 1);

	logic [N_W-1:0]   left_q;
	logic [N_W-1:0]   idx_q;
	logic [HB-1:0]    sh_q;
	logic [LIM_W-1:0] lim_q;
	logic [N_W-1:0]   cnt_q;
	logic             take;

	assign take = sh_q[0] && (LIM_W'(idx_q) < lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (start) begin
			left_q <= N_W'(HB);
		end else if (left_q != '0) begin
			left_q <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= hist;
			lim_q <= limit;
			idx_q <= '0;
			cnt_q <= '0;
		end else if (left_q != '0) begin
			sh_q  <= sh_q >> 1;
			idx_q <= idx_q + 1'b1;
			cnt_q <= cnt_q + N_W'(take);
		end
	end

	assign busy  = left_q != '0;
	assign count = cnt_q;

endmodule

// ===== tb/busy_fraction_worker_governor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Busy fraction worker governor testbench
// Sends frame stamp pairs through the valid/stall input channel and checks
// each busy fraction, worker count and change code against a cycle-free
// predictor of the ring, the histories and the grow/shrink decision.
// Several register settings, directed corner frames and random traffic
// shaped as steady frame streams with broken and noisy frames mixed in.
// ----------------------------------------------------------------------------
module busy_fraction_worker_governor_unit_tb;
	import bfwg_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD    = 400;
	localparam int PHASE_FRAMES = 215;

	typedef struct packed {
		logic [STAMP_W-1:0] t_start;
		logic [STAMP_W-1:0] t_end;
	} frame_t;

	typedef struct packed {
		logic [FRAC_W-1:0] frac;
		logic [WORK_W-1:0] workers;
		logic [1:0]        change;
	} verdict_t;

	typedef enum int {
		IDLE_SEND_RARE,
		IDLE_RECV_RARE,
		IDLE_OFF
	} idling_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                cfg_wen      = 1'b0;
	logic [IDX_W-1:0]    cfg_index    = '0;
	logic [CFG_W-1:0]    cfg_data     = '0;
	logic                frame_valid  = 1'b0;
	logic                frame_stall;
	logic [STAMP_W-1:0]  frame_start  = '0;
	logic [STAMP_W-1:0]  frame_end    = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [FRAC_W-1:0]   busy_frac;
	logic [WORK_W-1:0]   worker_count;
	logic [1:0]          count_change;

	frame_t   frames_to_send[$];
	verdict_t pending_verdicts[$];
	frame_t   staged_frame;
	verdict_t want_v;
	bit       frame_taken = 1'b0;

	int sender_idle_pct = 0;
	int recv_idle_pct   = 0;
	int hold_requests   = 0;
	int holds_served    = 0;
	int hold_left       = 0;
	int mismatch_count  = 0;
	int cycle_count     = 0;
	logic [STAMP_W-1:0] tick_now = '0;

	// predictor state and register copies
	logic [STAMP_W-1:0]          stamp_ring[RING_DEPTH_DEF];
	int                          ring_ptr;
	logic [HISTORY_BITS_DEF-1:0] slow_bits;
	logic [HISTORY_BITS_DEF-1:0] fast_bits;
	logic [WORK_W-1:0]           settle_count;
	logic [WORK_W-1:0]           workers_now;
	logic [FRAC_W-1:0]           slow_thr;
	logic [FRAC_W-1:0]           fast_thr;
	logic [WORK_W-1:0]           max_work;
	logic [WIN_W-1:0]            window_len;
	logic [WIN_W-1:0]            tolerance;
	logic [WORK_W-1:0]           settle_len;

	busy_fraction_worker_governor_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame_start  (frame_start),
		.frame_end    (frame_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.busy_frac    (busy_frac),
		.worker_count (worker_count),
		.count_change (count_change)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic verdict_t judge_frame(input logic [STAMP_W-1:0] t0,
			input logic [STAMP_W-1:0] t1);
		verdict_t           v;
		int                 back_ptr;
		logic [STAMP_W-1:0] old_end;
		logic [63:0]        busy_ticks;
		logic [63:0]        span_ticks;
		logic [63:0]        scaled;
		logic [63:0]        win_mask;
		int unsigned        w;
		int unsigned        nslow;
		int unsigned        nfast;
		v.change = CHG_NONE;
		back_ptr = (ring_ptr + RING_DEPTH_DEF - SPAN_FRAMES_DEF % RING_DEPTH_DEF)
			% RING_DEPTH_DEF;
		stamp_ring[ring_ptr] = t1;
		old_end = stamp_ring[back_ptr];
		ring_ptr = (ring_ptr + 1) % RING_DEPTH_DEF;

		if (t1 <= old_end) begin
			v.frac = FRAC_MAX;
		end else if (t1 < t0) begin
			v.frac = '0;
		end else begin
			busy_ticks = t1 - t0;
			span_ticks = t1 - old_end;
			scaled = busy_ticks * SPAN_FRAMES_DEF;
			if (scaled >= span_ticks * 16)
				v.frac = FRAC_MAX;
			else
				v.frac = FRAC_W'((scaled << 12) / span_ticks);
		end

		if (settle_count == 0) begin
			slow_bits = (slow_bits << 1) | (v.frac > slow_thr);
			fast_bits = (fast_bits << 1) | (v.frac < fast_thr);
			w = (window_len > HISTORY_BITS_DEF) ? HISTORY_BITS_DEF : window_len;
			win_mask = (64'd1 << w) - 64'd1;
			nslow = $countones(slow_bits & win_mask[HISTORY_BITS_DEF-1:0]);
			nfast = $countones(fast_bits & win_mask[HISTORY_BITS_DEF-1:0]);
			if (nslow > tolerance && workers_now < max_work) begin
				workers_now++;
				v.change = CHG_GROW;
			end else if (nslow == 0 && nfast + tolerance >= w && workers_now > 1) begin
				workers_now--;
				v.change = CHG_SHRINK;
			end
			if (v.change != CHG_NONE) begin
				slow_bits = '0;
				fast_bits = '0;
				settle_count = settle_len;
			end
		end else begin
			settle_count--;
		end
		v.workers = workers_now;
		return v;
	endfunction

	task automatic report(input string what, input longint unsigned got,
			input longint unsigned want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
	endtask

	// input channel driver
	always @(negedge clk) begin
		if (!arst_n) begin
			frame_valid <= 1'b0;
		end else if (!frame_valid || frame_taken) begin
			if (frames_to_send.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				staged_frame = frames_to_send.pop_front();
				frame_valid <= 1'b1;
				frame_start <= staged_frame.t_start;
				frame_end   <= staged_frame.t_end;
			end else begin
				frame_valid <= 1'b0;
			end
		end
	end

	// result channel stall, with long hold-offs on request
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (holds_served != hold_requests) begin
				hold_left = LONG_HOLD;
				holds_served = hold_requests;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			frame_taken = frame_valid && !frame_stall;
			if (result_valid && !result_stall) begin
				if (pending_verdicts.size() == 0) begin
					report("unexpected result, busy_frac", busy_frac, 0);
				end else begin
					want_v = pending_verdicts.pop_front();
					if (busy_frac !== want_v.frac)
						report("busy_frac", busy_frac, want_v.frac);
					if (worker_count !== want_v.workers)
						report("worker_count", worker_count, want_v.workers);
					if (count_change !== want_v.change)
						report("count_change", count_change, want_v.change);
				end
			end
			if (frame_taken)
				pending_verdicts.push_back(judge_frame(frame_start, frame_end));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("busy_fraction_worker_governor_unit test failed");
			$finish;
		end
	end

	task automatic push_frame(input logic [STAMP_W-1:0] t0, input logic [STAMP_W-1:0] t1);
		frame_t f;
		f.t_start = t0;
		f.t_end = t1;
		frames_to_send.push_back(f);
	endtask

	task automatic wait_drained();
		while (frames_to_send.size() > 0 || frame_valid || pending_verdicts.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_SLOW_THR: slow_thr   = val;
			REG_FAST_THR: fast_thr   = val;
			REG_MAX_WORK: max_work   = val[WORK_W-1:0];
			REG_WINDOW:   window_len = val[WIN_W-1:0];
			REG_TOLER:    tolerance  = val[WIN_W-1:0];
			REG_SETTLE:   settle_len = val[WORK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [FRAC_W-1:0] s_thr,
			input logic [FRAC_W-1:0] f_thr, input logic [WORK_W-1:0] m_work,
			input logic [WIN_W-1:0] win, input logic [WIN_W-1:0] tol,
			input logic [WORK_W-1:0] settle);
		write_reg(REG_SLOW_THR, s_thr);
		write_reg(REG_FAST_THR, f_thr);
		write_reg(REG_MAX_WORK, CFG_W'(m_work));
		write_reg(REG_WINDOW, CFG_W'(win));
		write_reg(REG_TOLER, CFG_W'(tol));
		write_reg(REG_SETTLE, CFG_W'(settle));
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_idling(input idling_t mode);
		case (mode)
			IDLE_SEND_RARE: begin
				sender_idle_pct = 18;
				recv_idle_pct = 63;
			end
			IDLE_RECV_RARE: begin
				sender_idle_pct = 63;
				recv_idle_pct = 18;
			end
			default: begin
				sender_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// steady frame streams in load regimes, with broken and noisy frames
	task automatic make_traffic(input int count);
		int                 regime_left;
		int                 load_lo;
		int                 load_hi;
		int                 pick;
		logic [63:0]        period;
		logic [63:0]        busy;
		logic [STAMP_W-1:0] t0;
		logic [STAMP_W-1:0] t1;
		regime_left = 0;
		load_lo = 0;
		load_hi = 50;
		period = 1000;
		for (int i = 0; i < count; i++) begin
			if (regime_left == 0) begin
				regime_left = $urandom_range(4, 40);
				period = $urandom_range(200, 60000);
				case ($urandom_range(0, 2))
					0: begin
						load_lo = 5;
						load_hi = 45;
					end
					1: begin
						load_lo = 40;
						load_hi = 95;
					end
					default: begin
						load_lo = 75;
						load_hi = 180;
					end
				endcase
				if ($urandom_range(0, 9) == 0)
					tick_now = {16'($urandom()), $urandom()};
			end
			regime_left--;
			busy = period * $urandom_range(load_lo, load_hi) / 100;
			pick = $urandom_range(0, 99);
			if (pick < 86) begin
				t1 = tick_now + STAMP_W'(period);
				t0 = t1 - STAMP_W'(busy);
				tick_now = t1;
			end else if (pick < 94) begin
				case ($urandom_range(0, 2))
					0: begin
						t1 = tick_now + STAMP_W'(period);
						t0 = t1 + STAMP_W'(busy) + 1;
						tick_now = t1;
					end
					1: begin
						t1 = tick_now - STAMP_W'(period * 8);
						t0 = t1 - STAMP_W'(busy);
					end
					default: begin
						t1 = tick_now;
						t0 = t1;
					end
				endcase
			end else begin
				t0 = {16'($urandom()), $urandom()};
				t1 = {16'($urandom()), $urandom()};
				if ($urandom_range(0, 3) == 0)
					t1 = '1;
				if ($urandom_range(0, 3) == 0)
					t0 = '0;
			end
			push_frame(t0, t1);
		end
	endtask

	task automatic run_phase(input logic [FRAC_W-1:0] s_thr,
			input logic [FRAC_W-1:0] f_thr, input logic [WORK_W-1:0] m_work,
			input logic [WIN_W-1:0] win, input logic [WIN_W-1:0] tol,
			input logic [WORK_W-1:0] settle, input idling_t mode, input bit long_hold);
		wait_drained();
		apply_settings(s_thr, f_thr, m_work, win, tol, settle);
		set_idling(mode);
		make_traffic(PHASE_FRAMES / 2);
		if (long_hold)
			hold_requests++;
		// hold the sender until every pending result is back
		wait_drained();
		make_traffic(PHASE_FRAMES - PHASE_FRAMES / 2);
	endtask

	initial begin
		for (int i = 0; i < RING_DEPTH_DEF; i++)
			stamp_ring[i] = '0;
		ring_ptr     = 0;
		slow_bits    = '0;
		fast_bits    = '0;
		slow_thr     = SLOW_THR_RST;
		fast_thr     = FAST_THR_RST;
		max_work     = MAX_WORK_RST;
		window_len   = WINDOW_RST;
		tolerance    = TOLER_RST;
		settle_len   = SETTLE_RST;
		settle_count = SETTLE_RST;
		workers_now  = WORKERS_RST;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		set_idling(IDLE_SEND_RARE);

		// zero divisor, idle frame at the top stamp, full-range busy time,
		// alternating bit patterns, end before start
		push_frame('0, '0);
		push_frame('1, '1);
		push_frame('0, '1);
		push_frame(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
		push_frame(48'd100, 48'd50);
		push_frame(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
		wait_drained();

		// settle out, grow, grow blocked at the limit, shrink, shrink blocked at one
		apply_settings(SLOW_THR_RST, FAST_THR_RST, 8'd2, 6'd2, 6'd0, 8'd0);
		tick_now = 48'd1_000_000;
		for (int i = 0; i < 15; i++) begin
			tick_now += 48'd1000;
			push_frame(tick_now - ((i < 11) ? 48'd950 : 48'd200), tick_now);
		end

		run_phase(16'd3400, 16'd2400, 8'd6, 6'd12, 6'd2, 8'd4, IDLE_SEND_RARE, 1'b1);
		run_phase(16'd0, 16'hFFFF, 8'd255, 6'd32, 6'd0, 8'd2, IDLE_SEND_RARE, 1'b0);
		run_phase(16'd3277, 16'd0, 8'd1, 6'd0, 6'd32, 8'd255, IDLE_RECV_RARE, 1'b0);
		run_phase(16'hFFFF, 16'd2500, 8'd4, 6'd63, 6'd63, 8'd1, IDLE_RECV_RARE, 1'b1);
		run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			8'($urandom_range(1, 255)), 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63)), 8'($urandom_range(0, 20)), IDLE_OFF, 1'b0);
		run_phase(16'd3277, 16'd2048, 8'd8, 6'd1, 6'd0, 8'd0, IDLE_OFF, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("busy_fraction_worker_governor_unit test passed");
		end else begin
			$display("busy_fraction_worker_governor_unit test failed");
		end
		$finish;
	end

endmodule
